FILE: src/virtqueue_descriptor_manager_macros.svh
// Assertion macros for the checker file of the descriptor manager.
`ifndef VIRTQUEUE_DESCRIPTOR_MANAGER_MACROS_SVH
`define VIRTQUEUE_DESCRIPTOR_MANAGER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define VQDM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vqdm: implication check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define VQDM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vqdm: next-cycle check failed");

`endif

FILE: src/vqdm_pkg.sv
`default_nettype none

package vqdm_pkg;

    // Queue geometry and field widths
    localparam int QUEUE_SIZE   = 8;
    localparam int SLOT_W       = 3;
    localparam int CNT_W        = 4;
    localparam int ADDR_W       = 48;
    localparam int SECTOR_W     = 64;
    localparam int LEN_W        = 10;
    localparam int BLOCK_BYTES  = 512;
    localparam int HDR_BYTES    = 16;
    localparam int SUBMIT_DESCS = 3;

    // Request types
    localparam logic REQ_SUBMIT  = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result word kinds
    localparam logic [2:0] KIND_HDR   = 3'd0;
    localparam logic [2:0] KIND_DESC  = 3'd1;
    localparam logic [2:0] KIND_AVAIL = 3'd2;
    localparam logic [2:0] KIND_REL   = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    // Descriptor flag bits
    localparam logic [1:0] F_NONE  = 2'b00;
    localparam logic [1:0] F_NEXT  = 2'b01;
    localparam logic [1:0] F_WRITE = 2'b10;

    typedef struct packed {
        logic                req_type;
        logic                is_write;
        logic [SECTOR_W-1:0] sector;
        logic [ADDR_W-1:0]   data_addr;
        logic [ADDR_W-1:0]   hdr_addr;
        logic [SLOT_W-1:0]   chain_head;
    } t_req;

    typedef struct packed {
        logic [2:0]          kind;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   addr;
        logic [LEN_W-1:0]    length;
        logic [1:0]          desc_flag_bits;
        logic [SLOT_W-1:0]   next_slot;
        logic [SLOT_W-1:0]   ring_pos;
        logic                hdr_type;
        logic [SECTOR_W-1:0] hdr_sector;
        logic [CNT_W-1:0]    free_left;
        logic                last;
    } t_rsp;

    // One entry of the descriptor link table
    typedef struct packed {
        logic [1:0]        flags;
        logic [SLOT_W-1:0] next;
    } t_link;

    // Link table access from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_link             wr_data;
        logic [SLOT_W-1:0] rd_addr;
    } t_ram_cmd;

    // Value of a table entry straight after reset
    function automatic t_link link_reset(input logic [SLOT_W-1:0] idx);
        t_link v;
        if (idx == SLOT_W'(QUEUE_SIZE - 1)) begin
            v.flags = F_NONE;
            v.next  = '0;
        end else begin
            v.flags = F_NEXT;
            v.next  = idx + SLOT_W'(1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: src/vqdm_link_ram.sv
`default_nettype none

module vqdm_link_ram (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vqdm_pkg::t_ram_cmd i_cmd,
    output vqdm_pkg::t_link        o_rdata
);

    vqdm_pkg::t_link                      r_mem [vqdm_pkg::QUEUE_SIZE];
    logic [vqdm_pkg::QUEUE_SIZE-1:0]      r_vld;
    vqdm_pkg::t_link                      r_rdata;

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_vld[i_cmd.wr_addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
    end

    // Registered read; an unwritten entry reads as its reset value
    always_ff @(posedge i_clk) begin
        if (r_vld[i_cmd.rd_addr]) begin
            r_rdata <= r_mem[i_cmd.rd_addr];
        end else begin
            r_rdata <= vqdm_pkg::link_reset(i_cmd.rd_addr);
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/vqdm_seq.sv
`default_nettype none

module vqdm_seq #(
    parameter int STATUS_STRIDE = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire vqdm_pkg::t_req                i_in_word,
    input  wire logic [vqdm_pkg::ADDR_W-1:0]   i_status_base,
    output logic                               o_emit,
    input  wire logic                          i_emit_ready,
    output vqdm_pkg::t_rsp                     o_emit_word,
    output vqdm_pkg::t_ram_cmd                 o_ram_cmd,
    input  wire vqdm_pkg::t_link               i_ram_rdata
);

    localparam int SLOT_W   = vqdm_pkg::SLOT_W;
    localparam int CNT_W    = vqdm_pkg::CNT_W;
    localparam int ADDR_W   = vqdm_pkg::ADDR_W;
    localparam int LEN_W    = vqdm_pkg::LEN_W;
    localparam int STRIDE_W = $clog2(STATUS_STRIDE + 1);
    localparam int OFF_W    = SLOT_W + STRIDE_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_POP0  = 4'd1;
    localparam logic [3:0] ST_POP1  = 4'd2;
    localparam logic [3:0] ST_POP2  = 4'd3;
    localparam logic [3:0] ST_HDR   = 4'd4;
    localparam logic [3:0] ST_DESC0 = 4'd5;
    localparam logic [3:0] ST_DESC1 = 4'd6;
    localparam logic [3:0] ST_DESC2 = 4'd7;
    localparam logic [3:0] ST_AVAIL = 4'd8;
    localparam logic [3:0] ST_WALK  = 4'd9;
    localparam logic [3:0] ST_FIX   = 4'd10;
    localparam logic [3:0] ST_REL   = 4'd11;
    localparam logic [3:0] ST_ERR   = 4'd12;

    logic [3:0]        r_state, n_state;
    vqdm_pkg::t_req    r_req, n_req;
    logic [SLOT_W-1:0] r_list_head, n_list_head;
    logic [CNT_W-1:0]  r_free_cnt, n_free_cnt;
    logic [SLOT_W-1:0] r_ring, n_ring;
    logic [SLOT_W-1:0] r_d0, n_d0;
    logic [SLOT_W-1:0] r_d1, n_d1;
    logic [SLOT_W-1:0] r_d2, n_d2;
    logic [SLOT_W-1:0] r_e0nx, n_e0nx;
    logic [SLOT_W-1:0] r_p1nx, n_p1nx;
    logic [SLOT_W-1:0] r_new_head, n_new_head;
    logic [SLOT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_steps, n_steps;
    logic              r_empty, n_empty;

    logic              accept;
    logic              e1_nb, e2_nb;
    logic [SLOT_W-1:0] e1_nx, e2_nx;
    logic [SLOT_W-1:0] d1_c, d2_c;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  submit_left;
    logic [1:0]        f1;
    logic [OFF_W-1:0]  st_off;
    logic [ADDR_W-1:0] status_addr;
    vqdm_pkg::t_link   tail_entry;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    // Forward the pending edits of earlier pops into the later ones
    assign d1_c  = i_ram_rdata.flags[0] ? i_ram_rdata.next : r_d0;
    assign e1_nb = (r_d1 == r_d0) ? 1'b1 : i_ram_rdata.flags[0];
    assign e1_nx = (r_d1 == r_d0) ? r_e0nx : i_ram_rdata.next;
    assign d2_c  = e1_nb ? e1_nx : r_d1;

    always_comb begin
        priority if (r_d2 == r_d1) begin
            e2_nb = 1'b1;
            e2_nx = r_p1nx;
        end else if (r_d2 == r_d0) begin
            e2_nb = 1'b1;
            e2_nx = r_d1;
        end else begin
            e2_nb = i_ram_rdata.flags[0];
            e2_nx = i_ram_rdata.next;
        end
    end

    // Saturating free count for one more released link
    assign cnt_inc = (r_cnt < CNT_W'(vqdm_pkg::QUEUE_SIZE)) ? r_cnt + CNT_W'(1) : r_cnt;

    assign submit_left = r_free_cnt - CNT_W'(vqdm_pkg::SUBMIT_DESCS);
    assign f1          = vqdm_pkg::F_NEXT | (r_req.is_write ? vqdm_pkg::F_NONE
                                                            : vqdm_pkg::F_WRITE);
    assign st_off      = OFF_W'(r_d0) * OFF_W'(STATUS_STRIDE);
    assign status_addr = i_status_base + ADDR_W'(st_off);

    // Relinked tail of a released chain
    assign tail_entry.flags = vqdm_pkg::F_NEXT;
    assign tail_entry.next  = r_empty ? i_ram_rdata.next : r_list_head;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_list_head = r_list_head;
        n_free_cnt  = r_free_cnt;
        n_ring      = r_ring;
        n_d0        = r_d0;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_e0nx      = r_e0nx;
        n_p1nx      = r_p1nx;
        n_new_head  = r_new_head;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_steps     = r_steps;
        n_empty     = r_empty;

        o_ram_cmd         = '0;
        o_ram_cmd.rd_addr = r_list_head;
        o_emit            = 1'b0;
        o_emit_word       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_req = i_in_word;
                    if (i_in_word.req_type == vqdm_pkg::REQ_SUBMIT) begin
                        if (r_free_cnt < CNT_W'(vqdm_pkg::SUBMIT_DESCS)) begin
                            n_state = ST_ERR;
                        end else begin
                            n_d0    = r_list_head;
                            n_state = ST_POP0;
                        end
                    end else begin
                        o_ram_cmd.rd_addr = i_in_word.chain_head;
                        n_n     = i_in_word.chain_head;
                        n_cnt   = r_free_cnt;
                        n_empty = (r_free_cnt == '0);
                        n_steps = '0;
                        n_state = ST_WALK;
                    end
                end
            end
            // Pop the header descriptor
            ST_POP0: begin
                n_e0nx            = i_ram_rdata.next;
                n_d1              = d1_c;
                o_ram_cmd.rd_addr = d1_c;
                n_state           = ST_POP1;
            end
            // Pop the data descriptor
            ST_POP1: begin
                n_p1nx            = (r_d1 == r_d0) ? r_d1 : i_ram_rdata.next;
                n_d2              = d2_c;
                o_ram_cmd.rd_addr = d2_c;
                n_state           = ST_POP2;
            end
            // Pop the status descriptor
            ST_POP2: begin
                n_new_head = e2_nb ? e2_nx : r_d2;
                n_state    = ST_HDR;
            end
            ST_HDR: begin
                if (i_emit_ready) begin
                    o_emit                 = 1'b1;
                    o_emit_word.kind       = vqdm_pkg::KIND_HDR;
                    o_emit_word.slot       = r_d0;
                    o_emit_word.addr       = r_req.hdr_addr;
                    o_emit_word.length     = LEN_W'(vqdm_pkg::HDR_BYTES);
                    o_emit_word.hdr_type   = r_req.is_write;
                    o_emit_word.hdr_sector = r_req.sector;
                    o_emit_word.free_left  = submit_left;
                    n_state                = ST_DESC0;
                end
            end
            ST_DESC0: begin
                if (i_emit_ready) begin
                    o_emit                     = 1'b1;
                    o_emit_word.kind           = vqdm_pkg::KIND_DESC;
                    o_emit_word.slot           = r_d0;
                    o_emit_word.addr           = r_req.hdr_addr;
                    o_emit_word.length         = LEN_W'(vqdm_pkg::HDR_BYTES);
                    o_emit_word.desc_flag_bits = vqdm_pkg::F_NEXT;
                    o_emit_word.next_slot      = r_d1;
                    o_emit_word.free_left      = submit_left;
                    o_ram_cmd.wr_en            = 1'b1;
                    o_ram_cmd.wr_addr          = r_d0;
                    o_ram_cmd.wr_data.flags    = vqdm_pkg::F_NEXT;
                    o_ram_cmd.wr_data.next     = r_d1;
                    n_state                    = ST_DESC1;
                end
            end
            ST_DESC1: begin
                if (i_emit_ready) begin
                    o_emit                     = 1'b1;
                    o_emit_word.kind           = vqdm_pkg::KIND_DESC;
                    o_emit_word.slot           = r_d1;
                    o_emit_word.addr           = r_req.data_addr;
                    o_emit_word.length         = LEN_W'(vqdm_pkg::BLOCK_BYTES);
                    o_emit_word.desc_flag_bits = f1;
                    o_emit_word.next_slot      = r_d2;
                    o_emit_word.free_left      = submit_left;
                    o_ram_cmd.wr_en            = 1'b1;
                    o_ram_cmd.wr_addr          = r_d1;
                    o_ram_cmd.wr_data.flags    = f1;
                    o_ram_cmd.wr_data.next     = r_d2;
                    n_state                    = ST_DESC2;
                end
            end
            ST_DESC2: begin
                if (i_emit_ready) begin
                    o_emit                     = 1'b1;
                    o_emit_word.kind           = vqdm_pkg::KIND_DESC;
                    o_emit_word.slot           = r_d2;
                    o_emit_word.addr           = status_addr;
                    o_emit_word.length         = LEN_W'(1);
                    o_emit_word.desc_flag_bits = vqdm_pkg::F_WRITE;
                    o_emit_word.free_left      = submit_left;
                    o_ram_cmd.wr_en            = 1'b1;
                    o_ram_cmd.wr_addr          = r_d2;
                    o_ram_cmd.wr_data.flags    = vqdm_pkg::F_WRITE;
                    o_ram_cmd.wr_data.next     = '0;
                    n_state                    = ST_AVAIL;
                end
            end
            // Publish the ring entry and commit the free list
            ST_AVAIL: begin
                if (i_emit_ready) begin
                    o_emit                = 1'b1;
                    o_emit_word.kind      = vqdm_pkg::KIND_AVAIL;
                    o_emit_word.slot      = r_d0;
                    o_emit_word.ring_pos  = r_ring;
                    o_emit_word.free_left = submit_left;
                    o_emit_word.last      = 1'b1;
                    n_list_head           = r_new_head;
                    n_free_cnt            = submit_left;
                    n_ring                = r_ring + SLOT_W'(1);
                    n_state               = ST_IDLE;
                end
            end
            // Follow the chain one link a cycle
            ST_WALK: begin
                n_cnt = cnt_inc;
                if (!i_ram_rdata.flags[0]) begin
                    o_ram_cmd.wr_en   = 1'b1;
                    o_ram_cmd.wr_addr = r_n;
                    o_ram_cmd.wr_data = tail_entry;
                    n_list_head       = r_req.chain_head;
                    n_free_cnt        = cnt_inc;
                    n_state           = ST_REL;
                end else begin
                    n_n               = i_ram_rdata.next;
                    o_ram_cmd.rd_addr = i_ram_rdata.next;
                    n_steps           = r_steps + CNT_W'(1);
                    if (r_steps == CNT_W'(vqdm_pkg::QUEUE_SIZE - 1)) begin
                        n_state = ST_FIX;
                    end
                end
            end
            // Walk cut short: relink the entry reached last
            ST_FIX: begin
                o_ram_cmd.wr_en   = 1'b1;
                o_ram_cmd.wr_addr = r_n;
                o_ram_cmd.wr_data = tail_entry;
                n_list_head       = r_req.chain_head;
                n_free_cnt        = r_cnt;
                n_state           = ST_REL;
            end
            ST_REL: begin
                if (i_emit_ready) begin
                    o_emit                = 1'b1;
                    o_emit_word.kind      = vqdm_pkg::KIND_REL;
                    o_emit_word.slot      = r_req.chain_head;
                    o_emit_word.free_left = r_free_cnt;
                    o_emit_word.last      = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (i_emit_ready) begin
                    o_emit                = 1'b1;
                    o_emit_word.kind      = vqdm_pkg::KIND_ERR;
                    o_emit_word.free_left = r_free_cnt;
                    o_emit_word.last      = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_list_head <= '0;
            r_free_cnt  <= CNT_W'(vqdm_pkg::QUEUE_SIZE);
            r_ring      <= '0;
        end else begin
            r_state     <= n_state;
            r_list_head <= n_list_head;
            r_free_cnt  <= n_free_cnt;
            r_ring      <= n_ring;
        end
    end

    // Working registers of the current item
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_d0       <= n_d0;
        r_d1       <= n_d1;
        r_d2       <= n_d2;
        r_e0nx     <= n_e0nx;
        r_p1nx     <= n_p1nx;
        r_new_head <= n_new_head;
        r_n        <= n_n;
        r_cnt      <= n_cnt;
        r_steps    <= n_steps;
        r_empty    <= n_empty;
    end

endmodule

`default_nettype wire

FILE: src/virtqueue_descriptor_manager.sv
// Submit: accept, three pops, five result words, the first registered after the pops.
// Release: walks a chain of L links (at most 8, plus a fix-up state when the walk
// hits that limit). No-free error: one error word. New requests wait until the last
// is done. Rate is set by the single read port of the link table and one result word
// a cycle while the output is not stalled. Synchronous active-low reset restores the
// full free list, clears the avail index and status base; no clearing pass is needed.
`default_nettype none

module virtqueue_descriptor_manager #(
    parameter int STATUS_STRIDE = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [63:0]    pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire vqdm_pkg::t_req i_in_word,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output vqdm_pkg::t_rsp      o_out_word
);

    logic [vqdm_pkg::ADDR_W-1:0] r_status_base;
    logic                        r_out_valid;
    vqdm_pkg::t_rsp              r_out_word;

    logic                        cfg_wr;
    logic                        emit;
    logic                        emit_ready;
    vqdm_pkg::t_rsp              emit_word;
    vqdm_pkg::t_ram_cmd          ram_cmd;
    vqdm_pkg::t_link             ram_rdata;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == '0);
    assign prdata = (paddr == '0) ? {16'd0, r_status_base} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_base <= '0;
        end else if (cfg_wr) begin
            r_status_base <= pwdata[vqdm_pkg::ADDR_W-1:0];
        end
    end

    vqdm_seq #(
        .STATUS_STRIDE (STATUS_STRIDE)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .i_status_base (r_status_base),
        .o_emit        (emit),
        .i_emit_ready  (emit_ready),
        .o_emit_word   (emit_word),
        .o_ram_cmd     (ram_cmd),
        .i_ram_rdata   (ram_rdata)
    );

    vqdm_link_ram u_link_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ram_cmd),
        .o_rdata (ram_rdata)
    );

    // Output register: load when empty or when the held word leaves
    assign emit_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_ready) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ready && emit) begin
            r_out_word <= emit_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: src/vqdm_checker.sv
`default_nettype none

`include "virtqueue_descriptor_manager_macros.svh"

module vqdm_props (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           psel,
    input wire logic           penable,
    input wire logic           pwrite,
    input wire logic [3:0]     paddr,
    input wire logic [63:0]    pwdata,
    input wire logic [63:0]    prdata,
    input wire logic           pready,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire vqdm_pkg::t_req i_in_word,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire vqdm_pkg::t_rsp o_out_word
);

    logic in_acc;
    logic out_acc;
    logic out_held;
    logic cfg_wr;
    logic cfg_rd0;
    logic err_word;
    logic req_known;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_acc   = o_out_valid && !i_out_stall;
    assign out_held  = o_out_valid && i_out_stall;
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr == '0);
    assign cfg_rd0   = (paddr == '0);
    assign err_word  = out_acc && (o_out_word.kind == vqdm_pkg::KIND_ERR);
    assign req_known = (i_in_word.req_type == vqdm_pkg::REQ_SUBMIT)
                    || (i_in_word.req_type == vqdm_pkg::REQ_RELEASE);

    // A held result word stays put
    `VQDM_ASSERT_NXT(a_out_hold, out_held, o_out_valid && $stable(o_out_word))

    // Every accepted request makes the block stall further input
    `VQDM_ASSERT_NXT(a_busy_after_accept, in_acc && req_known, o_in_stall)

    // The status base reads back what was last written
    `VQDM_ASSERT_IMP(a_cfg_readback, cfg_wr ##1 cfg_rd0, prdata[47:0] == $past(pwdata[47:0]))

    // A no-free error only with fewer than three free, and it closes the request
    `VQDM_ASSERT_IMP(a_err_word, err_word, (o_out_word.free_left < 4'd3) && o_out_word.last)

endmodule

bind virtqueue_descriptor_manager vqdm_props u_vqdm_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
